// ===== sv/fco_pkg.sv =====
// shared types, constants and tables for the fly camera orientation block
`default_nettype none
package fco_pkg;

  // item kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_CURSOR = 2'd1;
  localparam logic [1:0] KIND_WHEEL  = 2'd2;
  localparam logic [1:0] KIND_MOVE   = 2'd3;

  // key directions
  localparam logic [2:0] KEY_FWD     = 3'd0;
  localparam logic [2:0] KEY_BACK    = 3'd1;
  localparam logic [2:0] KEY_LEFT    = 3'd2;
  localparam logic [2:0] KEY_RIGHT   = 3'd3;
  localparam logic [2:0] KEY_RELEASE = 3'd4;

  // configuration register indices
  localparam logic [2:0] CFG_SENS    = 3'd0;
  localparam logic [2:0] CFG_SPEED   = 3'd1;
  localparam logic [2:0] CFG_START_X = 3'd2;
  localparam logic [2:0] CFG_START_Y = 3'd3;
  localparam logic [2:0] CFG_START_Z = 3'd4;

  // fixed-point constants
  localparam logic signed [33:0] DEG90     = 34'sd5898240;
  localparam logic signed [33:0] DEG180    = 34'sd11796480;
  localparam logic signed [33:0] DEG360    = 34'sd23592960;
  localparam logic signed [33:0] PITCH_LIM = 34'sd5832704;
  localparam logic signed [31:0] YAW_RESET = -32'sd5898240;
  localparam logic [9:0]         ZOOM_MAX  = 10'd720;
  localparam logic signed [15:0] UNIT_Q14  = 16'sd16384;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int unsigned        CORDIC_STEPS = 18;
  localparam logic [15:0]        SENS_RESET  = 16'd6554;
  localparam logic [15:0]        SPEED_RESET = 16'd640;

  typedef logic signed [23:0] vec24_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         key_dir;
    logic [15:0]        delta_time;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic [9:0]         zoom;
  } out_t;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fco_cordic.sv =====
// iterative rotation cordic giving sine and cosine of an angle in degrees
`default_nettype none
module fco_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] angle_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  import fco_pkg::*;

  typedef enum logic {C_IDLE, C_RUN} cstate_e;

  cstate_e           state_q;
  logic [4:0]        step_q;
  logic              neg_q;
  logic              done_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [31:0] cos_q, sin_q;

  logic signed [33:0] ang_ext, dx, dy, at;

  assign ang_ext = 34'(angle_i);
  assign dx      = y_q >>> step_q;
  assign dy      = x_q >>> step_q;
  assign at      = 34'(atan_deg(step_q));

  // sequencer and shared shift/add datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            x_q    <= CORDIC_GAIN;
            y_q    <= '0;
            step_q <= '0;
            // fold into the half plane of the cordic
            if (ang_ext > DEG90) begin
              z_q   <= ang_ext - DEG180;
              neg_q <= 1'b1;
            end else if (ang_ext < -DEG90) begin
              z_q   <= ang_ext + DEG180;
              neg_q <= 1'b1;
            end else begin
              z_q   <= ang_ext;
              neg_q <= 1'b0;
            end
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          if (z_q >= 0) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + at;
          end
          if (step_q == 5'(CORDIC_STEPS - 1)) begin
            state_q <= C_IDLE;
          end
          step_q <= step_q + 5'd1;
        end
        default: state_q <= C_IDLE;
      endcase
      // result once the last step has landed
      if (state_q == C_RUN && step_q == 5'(CORDIC_STEPS - 1)) begin
        done_q <= 1'b1;
      end
    end
  end

  // final sign fix on the settled vector
  always_ff @(posedge clk_i) begin
    if (done_q) begin
      cos_q <= neg_q ? -x_q[31:0] : x_q[31:0];
      sin_q <= neg_q ? -y_q[31:0] : y_q[31:0];
    end
  end

  logic done2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done2_q <= 1'b0;
    end else begin
      done2_q <= done_q;
    end
  end

  assign done_o = done2_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
`default_nettype wire

// ===== sv/fco_norm.sv =====
// vector normaliser: bit-serial square root then bit-serial divide per component
`default_nettype none
module fco_norm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire fco_pkg::vec24_t vec_i [3],
  input  wire logic [47:0]     sum_i,
  output logic                 done_o,
  output logic signed [15:0]   res_o [3]
);
  import fco_pkg::*;

  typedef enum logic [1:0] {N_IDLE, N_SQRT, N_LOAD, N_DIV} nstate_e;

  nstate_e     state_q;
  logic [4:0]  cnt_q;
  logic [1:0]  comp_q;
  logic        done_q;
  vec24_t      vec_q [3];
  logic [47:0] v_q, res_q, bit_q;
  logic [23:0] n_q;
  logic [25:0] r_q;
  logic [14:0] low_q;
  logic [14:0] quo_q;
  logic signed [15:0] out_q [3];

  logic [47:0] trial;
  logic [23:0] mag;
  logic [38:0] num;
  logic [25:0] r2;
  logic [14:0] quo_n;
  logic [15:0] qc;

  assign trial = res_q + bit_q;
  assign mag   = vec_q[comp_q][23] ? 24'(-vec_q[comp_q]) : 24'(vec_q[comp_q]);
  // rounding term from the settled root, which holds through all three components
  assign num   = {1'b0, mag, 14'd0} + 39'(res_q[23:1]);
  assign r2    = {r_q[24:0], low_q[14]};
  assign quo_n = {quo_q[13:0], (r2 >= 26'(n_q))};
  assign qc    = ({1'b0, quo_n} > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : {1'b0, quo_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            vec_q   <= vec_i;
            v_q     <= sum_i;
            res_q   <= '0;
            bit_q   <= 48'd1 << 46;
            cnt_q   <= '0;
            state_q <= N_SQRT;
          end
        end
        // one result bit per cycle
        N_SQRT: begin
          if (v_q >= trial) begin
            v_q   <= v_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd23) begin
            comp_q  <= '0;
            state_q <= N_LOAD;
          end
        end
        N_LOAD: begin
          n_q <= res_q[23:0];
          if (res_q[23:0] == '0) begin
            // zero-length vector
            out_q[comp_q] <= '0;
            if (comp_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end
            comp_q <= comp_q + 2'd1;
          end else begin
            r_q     <= 26'(num[38:15]);
            low_q   <= num[14:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= N_DIV;
          end
        end
        // restoring divide, one quotient bit per cycle
        N_DIV: begin
          r_q   <= (r2 >= 26'(n_q)) ? r2 - 26'(n_q) : r2;
          quo_q <= quo_n;
          low_q <= {low_q[13:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd14) begin
            out_q[comp_q] <= vec_q[comp_q][23] ? -$signed(qc) : $signed(qc);
            if (comp_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              state_q <= N_LOAD;
            end
            comp_q <= comp_q + 2'd1;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/fly_camera_orientation.sv =====
// fly camera orientation: top level, sequencer, shared multiplier and state
//
// Input items arrive on in_valid_i / in_stall_o / in_data_i and each gives
// one result of the full camera state on out_valid_o / out_stall_i /
// out_data_o. A transfer happens when valid is high and stall is low.
// The block takes one item at a time: in_stall_o is high from the cycle
// after a transfer until the item's result is in the output register.
// Wheel, move, key release and unknown-direction key items go straight to
// the output step; other key items set the three velocity components;
// cursor items wrap yaw step by step, then run two 18-step cordic passes
// and three normalisations with a 24-step square root and 15-step divides,
// and every product goes through the single shared 33x33 multiplier.
// A new item may be taken while the previous result still waits; if the
// receiver stalls, a finished item holds in its last step until the output
// register frees up. Configuration writes through cfg_we_i / cfg_idx_i /
// cfg_data_i must be made by the user only while the block is idle, which
// the block does not enforce; a start write also loads that position
// component. Reset restores yaw -90, pitch 0, zoom 45 degrees, zero position
// and velocity and the default axis vectors, and leaves the output empty.
`default_nettype none
module fly_camera_orientation (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire fco_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output fco_pkg::out_t     out_data_o,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  import fco_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_KEY_MAG, S_KEY_MAGQ, S_KEY_MUL, S_KEY_WR,
    S_CUR_DX, S_CUR_DY, S_CUR_ANG, S_CUR_WRAP,
    S_CY_START, S_CY_WAIT, S_CP_START, S_CP_WAIT,
    S_RAW_X, S_RAW_Z, S_RAW_W,
    S_SQ_MUL, S_SQ_ACC, S_NRM_START, S_NRM_WAIT,
    S_X_M1, S_X_M2, S_X_ACC, S_DONE
  } state_e;

  typedef enum logic [1:0] {PH_FRONT, PH_RIGHT, PH_UP} phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [1:0] idx_q;
  logic       neg_q, use_right_q;

  logic [15:0] sens_q, speed_q;
  logic signed [31:0] yaw_q, pitch_q;
  logic [9:0]  zoom_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [15:0] front_q [3];
  logic signed [15:0] right_q [3];
  logic signed [15:0] up_q [3];

  in_t         item_q;
  logic [31:0] mag_q;
  logic signed [31:0] dx_q;
  logic signed [33:0] t_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  vec24_t      vec_q [3];
  logic [47:0] acc_q;
  logic signed [31:0] p1_q;
  logic signed [65:0] prod_q;

  logic       out_valid_q;
  out_t       out_q;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [15:0] dir_c;

  always_comb begin
    dir_c = use_right_q ? right_q[idx_q] : front_q[idx_q];
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_KEY_MAG: begin
        mul_a = $signed(33'(item_q.delta_time));
        mul_b = $signed(33'(speed_q));
      end
      S_KEY_MUL: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = 33'(dir_c);
      end
      S_CUR_DX: begin
        mul_a = 33'(item_q.x_offset);
        mul_b = $signed(33'(sens_q));
      end
      S_CUR_DY: begin
        mul_a = 33'(item_q.y_offset);
        mul_b = $signed(33'(sens_q));
      end
      S_RAW_X: begin
        mul_a = 33'(cy_q);
        mul_b = 33'(cp_q);
      end
      S_RAW_Z: begin
        mul_a = 33'(sy_q);
        mul_b = 33'(cp_q);
      end
      S_SQ_MUL: begin
        mul_a = 33'(vec_q[idx_q]);
        mul_b = 33'(vec_q[idx_q]);
      end
      S_X_M1: begin
        case (idx_q)
          2'd0: begin mul_a = 33'(right_q[1]); mul_b = 33'(front_q[2]); end
          2'd1: begin mul_a = 33'(right_q[2]); mul_b = 33'(front_q[0]); end
          default: begin mul_a = 33'(right_q[0]); mul_b = 33'(front_q[1]); end
        endcase
      end
      S_X_M2: begin
        case (idx_q)
          2'd0: begin mul_a = 33'(right_q[2]); mul_b = 33'(front_q[1]); end
          2'd1: begin mul_a = 33'(right_q[0]); mul_b = 33'(front_q[2]); end
          default: begin mul_a = 33'(right_q[1]); mul_b = 33'(front_q[0]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // cordic and normaliser
  logic               cor_start, cor_done;
  logic signed [31:0] cor_cos, cor_sin;
  logic               nrm_start, nrm_done;
  logic signed [15:0] nrm_res [3];

  assign cor_start = (state_q == S_CY_START) || (state_q == S_CP_START);
  assign nrm_start = (state_q == S_NRM_START);

  fco_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i ((state_q == S_CY_START) ? yaw_q : pitch_q),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  fco_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nrm_start),
    .vec_i   (vec_q),
    .sum_i   (acc_q),
    .done_o  (nrm_done),
    .res_o   (nrm_res)
  );

  // helper values
  logic in_xfer, out_load;
  logic signed [31:0] key_v;
  logic signed [31:0] dy_c;
  logic signed [33:0] pit_c;
  logic signed [17:0] zsum;
  logic signed [31:0] xdiff;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign key_v    = prod_q[53:22];
  assign dy_c     = prod_q[35:4];
  assign pit_c    = 34'(pitch_q) - 34'(dy_c);
  assign zsum     = $signed({8'd0, zoom_q}) - 18'(in_data_i.y_offset);
  assign xdiff    = p1_q - prod_q[31:0];

  // sequencer and camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FRONT;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      use_right_q <= 1'b0;
      sens_q      <= SENS_RESET;
      speed_q     <= SPEED_RESET;
      yaw_q       <= YAW_RESET;
      pitch_q     <= '0;
      zoom_q      <= ZOOM_MAX;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]   <= '0;
        vel_q[i]   <= '0;
        front_q[i] <= '0;
        right_q[i] <= '0;
        up_q[i]    <= '0;
      end
      front_q[2] <= -UNIT_Q14;
      right_q[0] <= UNIT_Q14;
      up_q[1]    <= UNIT_Q14;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SENS:    sens_q   <= cfg_data_i[15:0];
          CFG_SPEED:   speed_q  <= cfg_data_i[15:0];
          CFG_START_X: pos_q[0] <= cfg_data_i;
          CFG_START_Y: pos_q[1] <= cfg_data_i;
          CFG_START_Z: pos_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            item_q  <= in_data_i;
            state_q <= S_DONE;
            case (in_data_i.kind)
              KIND_KEY: begin
                idx_q <= '0;
                case (in_data_i.key_dir)
                  KEY_FWD: begin
                    neg_q <= 1'b0; use_right_q <= 1'b0; state_q <= S_KEY_MAG;
                  end
                  KEY_BACK: begin
                    neg_q <= 1'b1; use_right_q <= 1'b0; state_q <= S_KEY_MAG;
                  end
                  KEY_LEFT: begin
                    neg_q <= 1'b1; use_right_q <= 1'b1; state_q <= S_KEY_MAG;
                  end
                  KEY_RIGHT: begin
                    neg_q <= 1'b0; use_right_q <= 1'b1; state_q <= S_KEY_MAG;
                  end
                  KEY_RELEASE: begin
                    for (int i = 0; i < 3; i++) vel_q[i] <= '0;
                  end
                  default: ;
                endcase
              end
              KIND_CURSOR: state_q <= S_CUR_DX;
              KIND_WHEEL: begin
                if (zsum < 0) begin
                  zoom_q <= '0;
                end else if (zsum > $signed({8'd0, ZOOM_MAX})) begin
                  zoom_q <= ZOOM_MAX;
                end else begin
                  zoom_q <= zsum[9:0];
                end
              end
              default: begin
                for (int i = 0; i < 3; i++) pos_q[i] <= pos_q[i] + vel_q[i];
              end
            endcase
          end
        end

        // key: speed times delta time, then scale the direction
        S_KEY_MAG:  state_q <= S_KEY_MAGQ;
        S_KEY_MAGQ: begin
          mag_q   <= prod_q[31:0];
          state_q <= S_KEY_MUL;
        end
        S_KEY_MUL:  state_q <= S_KEY_WR;
        S_KEY_WR: begin
          vel_q[idx_q] <= neg_q ? -key_v : key_v;
          if (idx_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_KEY_MUL;
          end
        end

        // cursor: scale offsets, wrap yaw, clamp pitch
        S_CUR_DX: state_q <= S_CUR_DY;
        S_CUR_DY: begin
          dx_q    <= prod_q[35:4];
          state_q <= S_CUR_ANG;
        end
        S_CUR_ANG: begin
          t_q <= 34'(yaw_q) + 34'(dx_q) + DEG180;
          if (pit_c > PITCH_LIM) begin
            pitch_q <= 32'(PITCH_LIM);
          end else if (pit_c < -PITCH_LIM) begin
            pitch_q <= 32'(-PITCH_LIM);
          end else begin
            pitch_q <= pit_c[31:0];
          end
          state_q <= S_CUR_WRAP;
        end
        S_CUR_WRAP: begin
          if (t_q < 0) begin
            t_q <= t_q + DEG360;
          end else if (t_q >= DEG360) begin
            t_q <= t_q - DEG360;
          end else begin
            yaw_q   <= 32'(t_q - DEG180);
            state_q <= S_CY_START;
          end
        end

        // sine and cosine of yaw then pitch
        S_CY_START: state_q <= S_CY_WAIT;
        S_CY_WAIT: begin
          if (cor_done) begin
            cy_q    <= cor_cos;
            sy_q    <= cor_sin;
            state_q <= S_CP_START;
          end
        end
        S_CP_START: state_q <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (cor_done) begin
            cp_q    <= cor_cos;
            sp_q    <= cor_sin;
            state_q <= S_RAW_X;
          end
        end

        // raw front vector
        S_RAW_X: state_q <= S_RAW_Z;
        S_RAW_Z: begin
          vec_q[0] <= prod_q[63:40];
          state_q  <= S_RAW_W;
        end
        S_RAW_W: begin
          vec_q[2] <= prod_q[63:40];
          vec_q[1] <= 24'(sp_q >>> 10);
          phase_q  <= PH_FRONT;
          idx_q    <= '0;
          acc_q    <= '0;
          state_q  <= S_SQ_MUL;
        end

        // squared length, then normalise
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc_q <= acc_q + prod_q[47:0];
          if (idx_q == 2'd2) begin
            state_q <= S_NRM_START;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_NRM_START: state_q <= S_NRM_WAIT;
        S_NRM_WAIT: begin
          if (nrm_done) begin
            idx_q <= '0;
            acc_q <= '0;
            case (phase_q)
              PH_FRONT: begin
                front_q  <= nrm_res;
                vec_q[0] <= -(24'(nrm_res[2]) <<< 6);
                vec_q[1] <= '0;
                vec_q[2] <= 24'(nrm_res[0]) <<< 6;
                phase_q  <= PH_RIGHT;
                state_q  <= S_SQ_MUL;
              end
              PH_RIGHT: begin
                right_q <= nrm_res;
                state_q <= S_X_M1;
              end
              default: begin
                up_q    <= nrm_res;
                state_q <= S_DONE;
              end
            endcase
          end
        end

        // up = right x front
        S_X_M1: state_q <= S_X_M2;
        S_X_M2: begin
          p1_q    <= prod_q[31:0];
          state_q <= S_X_ACC;
        end
        S_X_ACC: begin
          vec_q[idx_q] <= xdiff[31:8];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            acc_q   <= '0;
            phase_q <= PH_UP;
            state_q <= S_SQ_MUL;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_X_M1;
          end
        end

        S_DONE: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pos_x   <= pos_q[0];
      out_q.pos_y   <= pos_q[1];
      out_q.pos_z   <= pos_q[2];
      out_q.front_x <= front_q[0];
      out_q.front_y <= front_q[1];
      out_q.front_z <= front_q[2];
      out_q.up_x    <= up_q[0];
      out_q.up_y    <= up_q[1];
      out_q.up_z    <= up_q[2];
      out_q.zoom    <= zoom_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // pitch stays inside its limits
  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (34'(pitch_q) <= PITCH_LIM) && (34'(pitch_q) >= -PITCH_LIM))
    else $error("pitch out of range");

  // yaw stays in [-180, 180)
  a_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (34'(yaw_q) < DEG180) && (34'(yaw_q) >= -DEG180))
    else $error("yaw out of range");

  // zoom never beyond its maximum
  a_zoom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zoom_q <= ZOOM_MAX)
    else $error("zoom out of range");

  // a transfer always starts work on the item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("item lost after transfer");

  // a pending result is never overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
